// ===== src/delay_line_credit_link_queue_unit_defines.svh =====
// Assertion helpers used by the queue unit RTL.
`ifndef DELAY_LINE_CREDIT_LINK_QUEUE_UNIT_DEFINES_SVH
`define DELAY_LINE_CREDIT_LINK_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLCQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dlcq_pkg.sv =====
`default_nettype none

package dlcq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  // Result kinds.
  localparam logic [1:0] KIND_OK    = 2'd0;
  localparam logic [1:0] KIND_DELIV = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // Input actions.
  localparam logic ACT_ARRIVAL     = 1'b0;
  localparam logic ACT_OPPORTUNITY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_DELAY  = 1'b0;
  localparam logic REG_CREDIT = 1'b1;

  localparam logic [15:0] CREDIT_RESET = 16'd1500;

  typedef struct packed {
    logic [31:0] entry_ms;
    logic [15:0] bytes;
    logic [15:0] tag;
  } pkt_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/delay_line_credit_link_queue_unit.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | action, now_ms, packet_tag, packet_bytes
// out_    | output    | out_valid/out_stall| kind, tag, bytes, latency, wasted, last
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index (0 delay, 1 credit), cfg_wdata
//
// An arrival passes through ST_ARR to its result. An opportunity walks the head
// packets, each walk step a queue read in ST_CHECK followed by a compare/update in
// ST_EVAL in the shared compare unit, and ends in ST_SUM. Output stalls hold the
// walk where a result is due. Synchronous active-low reset empties the queue,
// clears the earned credit and loads the credit register with 1500; the store is
// not cleared.
`default_nettype none
`include "delay_line_credit_link_queue_unit_defines.svh"

module delay_line_credit_link_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [15:0] in_packet_tag,
  input  wire logic [15:0] in_packet_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_packet_tag_res,
  output logic [15:0]      out_packet_bytes_res,
  output logic [31:0]      out_latency_ms,
  output logic [15:0]      out_wasted_bytes,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import dlcq_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ARR   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      earned_r, earned_nxt;
  logic [15:0]      credit_r, credit_nxt;
  logic [15:0]      waste_r, waste_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [1:0]       pend_kind_r, pend_kind_nxt;
  logic [15:0]      delay_ms_r, delay_ms_nxt;
  logic [15:0]      credit_bytes_r, credit_bytes_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [15:0]      out_tag_r, out_tag_nxt;
  logic [15:0]      out_bytes_r, out_bytes_nxt;
  logic [31:0]      out_lat_r, out_lat_nxt;
  logic [15:0]      out_waste_r, out_waste_nxt;
  logic             out_last_r, out_last_nxt;

  pkt_t             mem [QUEUE_DEPTH];
  pkt_t             rd_word_r;
  logic             mem_we;

  logic             out_free;
  logic             in_take;
  logic [32:0]      release_ms;
  logic             released;
  logic [16:0]      avail;
  logic             covers;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Shared compare unit for the head packet.
  assign release_ms = {1'b0, rd_word_r.entry_ms} + {17'd0, delay_ms_r};
  assign released   = (release_ms <= {1'b0, now_r});
  assign avail      = {1'b0, credit_r} + {1'b0, earned_r};
  assign covers     = (avail >= {1'b0, rd_word_r.bytes});

  always_comb begin
    state_nxt        = state_r;
    rd_ptr_nxt       = rd_ptr_r;
    wr_ptr_nxt       = wr_ptr_r;
    cnt_nxt          = cnt_r;
    earned_nxt       = earned_r;
    credit_nxt       = credit_r;
    waste_nxt        = waste_r;
    now_nxt          = now_r;
    pend_kind_nxt    = pend_kind_r;
    delay_ms_nxt     = delay_ms_r;
    credit_bytes_nxt = credit_bytes_r;
    mem_we           = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_bytes_nxt = out_bytes_r;
    out_lat_nxt   = out_lat_r;
    out_waste_nxt = out_waste_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELAY:  delay_ms_nxt     = cfg_wdata;
        REG_CREDIT: credit_bytes_nxt = cfg_wdata;
        default:    ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          now_nxt = in_now_ms;
          if (in_action == ACT_ARRIVAL) begin
            if (cnt_r == DEPTH_CNT) begin
              pend_kind_nxt = KIND_DROP;
            end else begin
              mem_we        = 1'b1;
              wr_ptr_nxt    = ptr_inc(wr_ptr_r);
              cnt_nxt       = cnt_r + CNT_W'(1);
              pend_kind_nxt = KIND_OK;
            end
            state_nxt = ST_ARR;
          end else begin
            credit_nxt = credit_bytes_r;
            waste_nxt  = '0;
            state_nxt  = ST_CHECK;
          end
        end
      end
      ST_ARR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_tag_nxt   = '0;
          out_bytes_nxt = '0;
          out_lat_nxt   = '0;
          out_waste_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CHECK: begin
        // The head word is read from the store during this cycle.
        if (credit_r == '0) begin
          state_nxt = ST_SUM;
        end else if (cnt_r == '0) begin
          waste_nxt = credit_r;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!released) begin
          waste_nxt = credit_r;
          state_nxt = ST_SUM;
        end else if (covers) begin
          if (rd_word_r.bytes == '0 || out_free) begin
            credit_nxt = 16'(avail - {1'b0, rd_word_r.bytes});
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            cnt_nxt    = cnt_r - CNT_W'(1);
            earned_nxt = '0;
            state_nxt  = ST_CHECK;
            // Zero-length packets leave the queue without a result.
            if (rd_word_r.bytes != '0) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_DELIV;
              out_tag_nxt   = rd_word_r.tag;
              out_bytes_nxt = rd_word_r.bytes;
              out_lat_nxt   = now_r - rd_word_r.entry_ms;
              out_waste_nxt = '0;
              out_last_nxt  = 1'b0;
            end
          end
        end else begin
          // The sum is below the length here, so it fits in 16 bits.
          earned_nxt = avail[15:0];
          credit_nxt = '0;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_OK;
          out_tag_nxt   = '0;
          out_bytes_nxt = '0;
          out_lat_nxt   = '0;
          out_waste_nxt = waste_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rd_ptr_r       <= '0;
      wr_ptr_r       <= '0;
      cnt_r          <= '0;
      earned_r       <= '0;
      delay_ms_r     <= '0;
      credit_bytes_r <= CREDIT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      cnt_r          <= cnt_nxt;
      earned_r       <= earned_nxt;
      delay_ms_r     <= delay_ms_nxt;
      credit_bytes_r <= credit_bytes_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    credit_r    <= credit_nxt;
    waste_r     <= waste_nxt;
    now_r       <= now_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_lat_r   <= out_lat_nxt;
    out_waste_r <= out_waste_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= '{entry_ms: in_now_ms, bytes: in_packet_bytes, tag: in_packet_tag};
    end
  end

  always_ff @(posedge clk) begin
    rd_word_r <= mem[rd_ptr_r];
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_packet_tag_res   = out_tag_r;
  assign out_packet_bytes_res = out_bytes_r;
  assign out_latency_ms       = out_lat_r;
  assign out_wasted_bytes     = out_waste_r;
  assign out_last             = out_last_r;

  `DLCQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= DEPTH_CNT, "entry count above queue depth")
  `DLCQ_ASSERT_NOW(a_ptr_match, 1'b1,
                   (wr_ptr_r == rd_ptr_r) == (cnt_r == '0 || cnt_r == DEPTH_CNT),
                   "queue pointers disagree with entry count")
  `DLCQ_ASSERT_NOW(a_eval_nonempty, state_r == ST_EVAL, cnt_r != '0,
                   "head evaluated on an empty queue")
  `DLCQ_ASSERT_NEXT(a_opp_start, in_take && in_action == ACT_OPPORTUNITY,
                    state_r == ST_CHECK && credit_r == $past(credit_bytes_r),
                    "opportunity did not load the credit")
  `DLCQ_ASSERT_NOW(a_deliv_not_last, out_valid_r && out_kind_r == KIND_DELIV, !out_last_r,
                   "delivery marked as final result")

endmodule

`default_nettype wire
